FILE: hdl/svcc_pkg.sv
// shared types, constants and helper functions for the sign vector compatibility checker
package svcc_pkg;

	localparam int STORE_DEPTH = 1024;
	localparam int MAX_DIM     = 16;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int SUP_W       = 16;
	localparam int PAT_W       = 8;
	localparam int DIM_W       = 5;
	localparam int IDX_W       = 10;
	localparam int GOOD_W      = 32;
	localparam int POP_W       = 5;

	localparam logic [DIM_W-1:0] DIM_RESET   = 5'd14;
	localparam logic [POP_W-1:0] WEIGHT      = 5'd8;
	localparam logic [POP_W-1:0] OVERLAP_MIN = 5'd4;
	localparam logic [POP_W-1:0] OVERLAP_MID = 5'd6;
	localparam logic [POP_W-1:0] NEED_LOW    = 5'd1;
	localparam logic [POP_W-1:0] NEED_HIGH   = 5'd2;

	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_LOAD  = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	typedef struct packed {
		logic [SUP_W-1:0] sup;
		logic [SUP_W-1:0] signs;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_SCAN,
		ST_DONE
	} state_t;

	function automatic logic [POP_W-1:0] popcnt(input logic [SUP_W-1:0] v);
		logic [POP_W-1:0] c;
		c = '0;
		for (int i = 0; i < SUP_W; i++) begin
			c = c + POP_W'(v[i]);
		end
		return c;
	endfunction

	// bits at or above the dimension (and at or above MAX_DIM) are dropped
	function automatic logic [SUP_W-1:0] dim_mask(input logic [DIM_W-1:0] dim);
		logic [SUP_W-1:0] m;
		for (int b = 0; b < SUP_W; b++) begin
			m[b] = (b < int'(dim)) && (b < MAX_DIM);
		end
		return m;
	endfunction

	// support bits take the pattern bit indexed by the set bits below; 0 past PAT_W
	function automatic logic [SUP_W-1:0] spread(input logic [SUP_W-1:0] sup,
			input logic [PAT_W-1:0] pat);
		logic [SUP_W-1:0] e;
		logic [POP_W-1:0] j;
		for (int b = 0; b < SUP_W; b++) begin
			j = popcnt(sup & SUP_W'((32'd1 << b) - 32'd1));
			e[b] = sup[b] && (j < POP_W'(PAT_W)) && pat[j[2:0]];
		end
		return e;
	endfunction

endpackage

FILE: hdl/svcc_store.sv
// entry memory: one write port, one read port with registered read data
module svcc_store (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [svcc_pkg::ADDR_W-1:0] wr_addr,
	input  svcc_pkg::entry_t           wr_data,
	input  logic                       rd_en,
	input  logic [svcc_pkg::ADDR_W-1:0] rd_addr,
	output svcc_pkg::entry_t           rd_data
);
	import svcc_pkg::*;

	entry_t mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: hdl/svcc_match.sv
// conflict test between the candidate and one stored entry
module svcc_match (
	input  svcc_pkg::entry_t cand,
	input  svcc_pkg::entry_t stored,
	output logic             conflict
);
	import svcc_pkg::*;

	logic [SUP_W-1:0] overlap;
	logic [POP_W-1:0] olap_cnt;
	logic [POP_W-1:0] diff_cnt;
	logic             near;

	assign overlap  = cand.sup & stored.sup;
	assign olap_cnt = popcnt(overlap);
	assign diff_cnt = popcnt((cand.signs ^ stored.signs) & overlap);

	// large overlap with too few sign differences on it
	always_comb begin
		if (olap_cnt <= OVERLAP_MIN) begin
			near = 1'b0;
		end else if (olap_cnt <= OVERLAP_MID) begin
			near = diff_cnt < NEED_LOW;
		end else begin
			near = diff_cnt < NEED_HIGH;
		end
	end

	assign conflict = (cand == stored) || near;

endmodule

FILE: hdl/sign_vector_compatibility_checker.sv
// top level: request control, entry scan sequencer, counters and result register
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+-------------------------
//  request   | mode, support, sign_pattern               | in_valid / in_ready
//  result    | compatible, conflict_index,               | out_valid / out_ready
//            | compatible_count, bad_support,            |
//            | store_overflow                            |
//  config    | dimension_wdata                           | dimension_we, no wait
//
// clear, load and the unused mode go from IDLE through PREP back to IDLE, with no result.
// a query goes through PREP, SCAN and DONE; one read of the entry memory per cycle while
// scanning, stopping at the first conflicting entry.
// arst_n clears counters, overflow flag and control; memory and payload hold no reset.
// a result that is not taken stalls the next query only; new requests are accepted meanwhile.
module sign_vector_compatibility_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        dimension_we,
	input  logic [svcc_pkg::DIM_W-1:0]  dimension_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  mode,
	input  logic [svcc_pkg::SUP_W-1:0]  support,
	input  logic [svcc_pkg::PAT_W-1:0]  sign_pattern,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        compatible,
	output logic [svcc_pkg::IDX_W-1:0]  conflict_index,
	output logic [svcc_pkg::GOOD_W-1:0] compatible_count,
	output logic                        bad_support,
	output logic                        store_overflow
);
	import svcc_pkg::*;

	state_t state_q, state_d;

	logic [DIM_W-1:0]  dim_q;
	logic [1:0]        mode_q;
	logic [SUP_W-1:0]  sup_q;
	logic [PAT_W-1:0]  pat_q;
	logic [SUP_W-1:0]  signs_q;
	logic              bad_q;
	logic [CNT_W-1:0]  entry_count_q;
	logic [CNT_W-1:0]  ptr_q;
	logic [GOOD_W-1:0] good_count_q;
	logic              overflow_q;
	logic              valid_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic              hit_q;
	logic [ADDR_W-1:0] hit_idx_q;
	logic              out_valid_q;

	logic              accept;
	logic              full;
	logic              wr_en;
	logic              rd_en;
	logic              hit_now;
	logic              scan_end;
	logic              emit;
	logic              conflict;
	logic [SUP_W-1:0]  spread_signs;
	entry_t            cand;
	entry_t            rd_data;

	assign accept       = in_valid && in_ready;
	assign full         = entry_count_q >= CNT_W'(STORE_DEPTH);
	assign spread_signs = spread(sup_q, pat_q);
	assign cand         = '{sup: sup_q, signs: signs_q};
	assign hit_now      = valid_s1 && conflict;
	assign scan_end     = ptr_q >= entry_count_q;

	svcc_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (entry_count_q[ADDR_W-1:0]),
		.wr_data ('{sup: sup_q, signs: spread_signs}),
		.rd_en   (rd_en),
		.rd_addr (ptr_q[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	svcc_match u_match (
		.cand     (cand),
		.stored   (rd_data),
		.conflict (conflict)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = (mode_q == MODE_QUERY) ? ST_SCAN : ST_IDLE;
			end
			ST_SCAN: begin
				if (hit_now || scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		emit     = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_PREP: wr_en = (mode_q == MODE_LOAD) && !full;
			ST_SCAN: rd_en = !hit_now && !scan_end;
			ST_DONE: emit = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			dim_q         <= DIM_RESET;
			entry_count_q <= '0;
			good_count_q  <= '0;
			overflow_q    <= 1'b0;
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			mode_q        <= MODE_CLEAR;
			ptr_q         <= '0;
			hit_q         <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dimension_we) begin
				dim_q <= dimension_wdata;
			end
			if (accept) begin
				mode_q <= mode;
			end
			if (state_q == ST_PREP) begin
				ptr_q <= '0;
				hit_q <= 1'b0;
				if (mode_q == MODE_CLEAR) begin
					entry_count_q <= '0;
					good_count_q  <= '0;
					overflow_q    <= 1'b0;
				end else if (mode_q == MODE_LOAD) begin
					if (full) begin
						overflow_q <= 1'b1;
					end else begin
						entry_count_q <= entry_count_q + CNT_W'(1);
					end
				end
			end
			// read issued this cycle is compared in the next
			valid_s1 <= rd_en;
			if (rd_en) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			if (hit_now) begin
				hit_q <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				if (!hit_q && good_count_q != '1) begin
					good_count_q <= good_count_q + GOOD_W'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sup_q <= support & dim_mask(dim_q);
			pat_q <= sign_pattern;
		end
		if (state_q == ST_PREP) begin
			signs_q <= spread_signs;
			bad_q   <= popcnt(sup_q) != WEIGHT;
		end
		if (rd_en) begin
			idx_s1 <= ptr_q[ADDR_W-1:0];
		end
		if (hit_now) begin
			hit_idx_q <= idx_s1;
		end
		if (emit) begin
			compatible       <= !hit_q;
			conflict_index   <= hit_q ? IDX_W'(hit_idx_q) : '0;
			compatible_count <= (!hit_q && good_count_q != '1) ?
				good_count_q + GOOD_W'(1) : good_count_q;
			bad_support      <= bad_q;
			store_overflow   <= overflow_q;
		end
	end

	assign out_valid = out_valid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CNT_W'(STORE_DEPTH))
		else $error("entry count beyond store depth");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full && state_q == ST_PREP)
		else $error("entry written into a full store");

	a_compare_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> state_q == ST_SCAN)
		else $error("entry compare outside the scan");

	a_overflow_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(overflow_q) |-> entry_count_q == CNT_W'(STORE_DEPTH))
		else $error("overflow raised with room in the store");

	a_index_on_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && compatible |-> conflict_index == '0)
		else $error("conflict index set on a compatible result");

endmodule
